FILE: src/brle_pkg.sv
// Shared types and constants for the BMP RLE8 decoder.
// Depends on nothing; every other file in src uses it by scoped names.
`timescale 1ns / 1ps

package brle_pkg;

    localparam int POS_W    = 13;   // column, row and config fields
    localparam int STRIDE_W = 14;   // stride reaches 8192
    localparam int COUNT_W  = 25;   // repeat count on the output
    localparam int PROD_W   = POS_W + STRIDE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0]    POS_MAX      = '1;
    localparam logic [COUNT_W-1:0]  CNT_MAX      = '1;
    localparam logic [STRIDE_W-1:0] STRIDE_ROUND = 14'd3;
    localparam logic [STRIDE_W-1:0] STRIDE_MASK  = ~STRIDE_ROUND;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_SECOND = 3'd1,
        PH_DX     = 3'd2,
        PH_DY     = 3'd3,
        PH_LIT    = 3'd4,
        PH_PAD    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       start_of_image;
    } t_code_in;

    typedef struct packed {
        logic [7:0]         pixel_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               end_of_image;
        logic               row_overrun;
    } t_seg_out;

    // Segment command: count = base + mult * stride.
    typedef struct packed {
        logic [7:0]          value;
        logic [STRIDE_W-1:0] base;
        logic [POS_W-1:0]    mult;
        logic                eoi;
        logic                ovr;
    } t_seg_cmd;

endpackage

FILE: src/brle_parser.sv
// Byte parser for the RLE8 stream: phase machine, position tracking and
// the registered segment command. Depends on brle_pkg.
`timescale 1ns / 1ps

module brle_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  brle_pkg::t_code_in             i_in_data,
    input  logic [brle_pkg::STRIDE_W-1:0]  i_stride,
    input  logic [brle_pkg::POS_W-1:0]     i_height,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready,
    output brle_pkg::t_seg_cmd             o_cmd
);

    brle_pkg::t_phase                r_phase, n_phase, c_phase;
    logic [7:0]                      r_held_count, n_held_count, c_held_count;
    logic [7:0]                      r_literal_left, n_literal_left, c_literal_left;
    logic                            r_literal_odd, n_literal_odd, c_literal_odd;
    logic [7:0]                      r_held_dx, n_held_dx, c_held_dx;
    logic [brle_pkg::POS_W-1:0]      r_col, n_col, c_col;
    logic [brle_pkg::POS_W-1:0]      r_row, n_row, c_row;
    logic                            r_done, n_done, c_done;
    logic                            r_cmd_valid;
    brle_pkg::t_seg_cmd              r_cmd, n_cmd;
    logic                            n_emit;
    logic                            take;
    logic [7:0]                      b;
    logic                            col_past;
    logic [brle_pkg::STRIDE_W-1:0]   eol_fill;
    logic [7:0]                      lit_dec;

    function automatic logic [brle_pkg::POS_W-1:0] sat_pos(
        input logic [brle_pkg::POS_W:0] v
    );
        sat_pos = v[brle_pkg::POS_W] ? brle_pkg::POS_MAX : v[brle_pkg::POS_W-1:0];
    endfunction

    assign o_in_ready  = !r_cmd_valid || i_cmd_ready;
    assign take        = i_in_valid && o_in_ready;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;
    assign b           = i_in_data.code_byte;

    // State as seen by this byte: start of image clears it first.
    always_comb begin
        if (i_in_data.start_of_image) begin
            c_phase        = brle_pkg::PH_COUNT;
            c_held_count   = '0;
            c_literal_left = '0;
            c_literal_odd  = 1'b0;
            c_held_dx      = '0;
            c_col          = '0;
            c_row          = '0;
            c_done         = 1'b0;
        end else begin
            c_phase        = r_phase;
            c_held_count   = r_held_count;
            c_literal_left = r_literal_left;
            c_literal_odd  = r_literal_odd;
            c_held_dx      = r_held_dx;
            c_col          = r_col;
            c_row          = r_row;
            c_done         = r_done;
        end
    end

    assign col_past = {1'b0, c_col} > i_stride;
    assign eol_fill = col_past ? '0 : i_stride - {1'b0, c_col};
    assign lit_dec  = c_literal_left - 8'd1;

    always_comb begin
        n_phase        = c_phase;
        n_held_count   = c_held_count;
        n_literal_left = c_literal_left;
        n_literal_odd  = c_literal_odd;
        n_held_dx      = c_held_dx;
        n_col          = c_col;
        n_row          = c_row;
        n_done         = c_done;
        n_emit         = 1'b0;
        n_cmd          = '{value: b, base: '0, mult: '0, eoi: 1'b0, ovr: 1'b0};
        if (!c_done) begin
            unique case (c_phase)
                brle_pkg::PH_COUNT: begin
                    n_held_count = b;
                    n_phase      = brle_pkg::PH_SECOND;
                end
                brle_pkg::PH_SECOND: begin
                    if (c_held_count != 8'd0) begin
                        n_phase    = brle_pkg::PH_COUNT;
                        n_col      = sat_pos({1'b0, c_col} + 14'(c_held_count));
                        n_emit     = 1'b1;
                        n_cmd.base = 14'(c_held_count);
                    end else begin
                        unique case (b)
                            brle_pkg::ESC_EOL: begin
                                n_col       = '0;
                                n_row       = sat_pos({1'b0, c_row} + 14'd1);
                                n_phase     = brle_pkg::PH_COUNT;
                                n_emit      = 1'b1;
                                n_cmd.value = 8'd0;
                                n_cmd.base  = eol_fill;
                                n_cmd.ovr   = col_past;
                            end
                            brle_pkg::ESC_EOB: begin
                                n_done      = 1'b1;
                                n_phase     = brle_pkg::PH_COUNT;
                                n_emit      = 1'b1;
                                n_cmd.value = 8'd0;
                                n_cmd.eoi   = 1'b1;
                                // Fill the rest of this row plus every whole row left.
                                if (c_row < i_height) begin
                                    n_cmd.base = eol_fill;
                                    n_cmd.ovr  = col_past;
                                    n_cmd.mult = i_height - c_row - 13'd1;
                                end
                            end
                            brle_pkg::ESC_DELTA: begin
                                n_phase = brle_pkg::PH_DX;
                            end
                            default: begin
                                n_literal_left = b;
                                n_literal_odd  = b[0];
                                n_phase        = brle_pkg::PH_LIT;
                            end
                        endcase
                    end
                end
                brle_pkg::PH_DX: begin
                    n_held_dx = b;
                    n_phase   = brle_pkg::PH_DY;
                end
                brle_pkg::PH_DY: begin
                    n_col       = sat_pos({1'b0, c_col} + 14'(c_held_dx));
                    n_row       = sat_pos({1'b0, c_row} + 14'(b));
                    n_phase     = brle_pkg::PH_COUNT;
                    n_emit      = 1'b1;
                    n_cmd.value = 8'd0;
                    n_cmd.base  = 14'(c_held_dx);
                    n_cmd.mult  = 13'(b);
                end
                brle_pkg::PH_LIT: begin
                    n_col          = sat_pos({1'b0, c_col} + 14'd1);
                    n_literal_left = lit_dec;
                    if (lit_dec == 8'd0) begin
                        n_phase = c_literal_odd ? brle_pkg::PH_PAD : brle_pkg::PH_COUNT;
                    end
                    n_emit     = 1'b1;
                    n_cmd.base = 14'd1;
                end
                brle_pkg::PH_PAD: begin
                    n_literal_odd = 1'b0;
                    n_phase       = brle_pkg::PH_COUNT;
                end
                default: begin
                    n_phase = brle_pkg::PH_COUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= brle_pkg::PH_COUNT;
            r_held_count   <= '0;
            r_literal_left <= '0;
            r_literal_odd  <= 1'b0;
            r_held_dx      <= '0;
            r_col          <= '0;
            r_row          <= '0;
            r_done         <= 1'b0;
            r_cmd_valid    <= 1'b0;
        end else begin
            if (take) begin
                r_phase        <= n_phase;
                r_held_count   <= n_held_count;
                r_literal_left <= n_literal_left;
                r_literal_odd  <= n_literal_odd;
                r_held_dx      <= n_held_dx;
                r_col          <= n_col;
                r_row          <= n_row;
                r_done         <= n_done;
            end
            if (o_in_ready) begin
                r_cmd_valid <= take && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

`ifndef SYNTHESIS
    a_lit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == brle_pkg::PH_LIT) |-> (r_literal_left != 8'd0))
        else $error("literal phase with no bytes left");
    a_pad_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == brle_pkg::PH_PAD) |-> r_literal_odd)
        else $error("pad phase after even literal run");
    a_eob_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && n_emit && n_cmd.eoi) |=> r_done)
        else $error("end of bitmap did not mark decode done");
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_done && !i_in_data.start_of_image) |=> !r_cmd_valid)
        else $error("segment emitted after end of bitmap");
`endif

endmodule

FILE: src/brle_fill.sv
// Count stage: base plus multiple of stride, saturated, into the output register.
// Depends on brle_pkg.
`timescale 1ns / 1ps

module brle_fill (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_ready,
    input  brle_pkg::t_seg_cmd             i_cmd,
    input  logic [brle_pkg::STRIDE_W-1:0]  i_stride,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output brle_pkg::t_seg_out             o_out_data
);

    logic                          r_out_valid;
    brle_pkg::t_seg_out            r_out, n_out;
    logic [brle_pkg::PROD_W-1:0]   product;
    logic [brle_pkg::PROD_W-1:0]   total;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign product = i_cmd.mult * i_stride;
    assign total   = product + brle_pkg::PROD_W'(i_cmd.base);

    always_comb begin
        n_out.pixel_value  = i_cmd.value;
        n_out.repeat_count = (total > brle_pkg::PROD_W'(brle_pkg::CNT_MAX))
                           ? brle_pkg::CNT_MAX : total[brle_pkg::COUNT_W-1:0];
        n_out.end_of_image = i_cmd.eoi;
        n_out.row_overrun  = i_cmd.ovr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_ready) begin
            r_out_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid && o_cmd_ready) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: src/bmp_rle8_decoder.sv
// Top level of the BMP RLE8 decoder: configuration registers, parser and count stage.
// Depends on brle_pkg, brle_parser and brle_fill.
`timescale 1ns / 1ps

// BMP RLE8 decoder. Feed the compressed stream one byte per input beat; each
// output beat is a run segment (pixel_value repeated repeat_count times).
// Encoded runs give one segment, absolute literals one segment of count 1 per
// byte, the pad byte after an odd literal is dropped, and end of line, delta
// and end of bitmap give zero-fill segments sized from the row stride (width
// rounded up to a multiple of 4). end_of_image marks the last segment; bytes
// after it are dropped until a beat with start_of_image set. Throughput is one
// byte per clock while the output accepts, with no stalls of its own; a segment
// is registered in the parser's command register and then in the count stage,
// which does the single stride multiply-add and saturation.
// Write image_width and image_height only while the block is idle; the config
// port is always ready and ignores unknown indexes.
module bmp_rle8_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  brle_pkg::t_code_in              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output brle_pkg::t_seg_out              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brle_pkg::POS_W-1:0]      i_cfg_data
);

    // Reset values: width 1 gives stride 4, height 1.
    localparam logic [brle_pkg::STRIDE_W-1:0] STRIDE_RESET = 14'd4;
    localparam logic [brle_pkg::POS_W-1:0]    HEIGHT_RESET = 13'd1;

    logic [brle_pkg::STRIDE_W-1:0] r_stride, n_stride;
    logic [brle_pkg::POS_W-1:0]    r_height, n_height;
    logic [brle_pkg::STRIDE_W-1:0] width_clamped;
    logic                          cfg_write;

    logic                          cmd_valid;
    logic                          cmd_ready;
    brle_pkg::t_seg_cmd            cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Clamp to the supported size, then round the stride up to a 4-byte multiple.
    assign width_clamped = (17'(i_cfg_data) > 17'(MAX_WIDTH))
                         ? brle_pkg::STRIDE_W'(MAX_WIDTH)
                         : brle_pkg::STRIDE_W'(i_cfg_data);
    assign n_stride = (width_clamped + brle_pkg::STRIDE_ROUND) & brle_pkg::STRIDE_MASK;
    assign n_height = (17'(i_cfg_data) > 17'(MAX_HEIGHT))
                    ? brle_pkg::POS_W'(MAX_HEIGHT) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            if (i_cfg_index == brle_pkg::CFG_IMAGE_WIDTH) begin
                r_stride <= n_stride;
            end
            if (i_cfg_index == brle_pkg::CFG_IMAGE_HEIGHT) begin
                r_height <= n_height;
            end
        end
    end

    // Parser: one byte per beat, emits a segment command when the byte ends one.
    brle_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_stride    (r_stride),
        .i_height    (r_height),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Count stage: resolve base + mult * stride and hold the result beat.
    brle_fill u_fill (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_stride    (r_stride),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
